### hw/rtl/eulr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eulr_pkg
// Shared types, constants and arithmetic helpers for the ZYX Euler rotation
// matrix pipeline.
// ----------------------------------------------------------------------------
package eulr_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int FRAC_BITS     = 14;
    localparam int CORDIC_STAGES = 16;
    localparam int WORK_FRAC     = 30;
    localparam int OUT_BITS      = FRAC_BITS + 2;

    // datapath widths
    localparam int XY_W = 36;   // CORDIC x/y, Q.32 plus headroom
    localparam int Z_W  = 34;   // residual angle, 2^32 per turn
    localparam int Q_W  = 34;   // Q.30 trig values and products
    localparam int S_W  = 35;   // sums of two products

    // pipeline depths
    localparam int CORD_LAT = CORDIC_STAGES + 2;  // pre-rotate, stages, round
    localparam int MUL_LAT  = 3;                  // two product levels, finish
    localparam int LAT      = CORD_LAT + MUL_LAT;

    typedef logic signed [Q_W-1:0]      t_q30;
    typedef logic signed [OUT_BITS-1:0] t_elem;

    typedef enum logic [1:0] {
        CMD_FULL  = 2'd0,
        CMD_ROLL  = 2'd1,
        CMD_PITCH = 2'd2,
        CMD_YAW   = 2'd3
    } t_cmd;

    // atan(2^-i) in 2^32-per-turn units
    localparam logic [31:0] ATAN_TURN [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // squared CORDIC gain, scaled by 2^60
    function automatic longint unsigned gain_sq();
        longint unsigned p;
        p = 64'd1 << 60;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
            p = p + (p >> (2 * i));
        end
        return p;
    endfunction

    function automatic longint unsigned isqrt64(longint unsigned n_in);
        longint unsigned n;
        longint unsigned r;
        longint unsigned b;
        n = n_in;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > n) begin
            b = b >> 2;
        end
        while (b != 64'd0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    localparam longint unsigned GAIN_ROOT = isqrt64(gain_sq());
    localparam longint unsigned CORD_K    = (64'd1 << 62) / GAIN_ROOT;

    localparam t_q30 Q_ONE = t_q30'(64'd1 << WORK_FRAC);

    // Q.30 multiply, round half up
    function automatic t_q30 fmul(t_q30 a, t_q30 b);
        logic signed [2*Q_W-1:0] p;
        p = (2*Q_W)'(a) * (2*Q_W)'(b);
        p = p + ((2*Q_W)'(1) <<< (WORK_FRAC - 1));
        p = p >>> WORK_FRAC;
        return p[Q_W-1:0];
    endfunction

    // round Q.30 to Q1.FRAC_BITS and saturate to +-1.0
    function automatic t_elem finish(logic signed [S_W-1:0] e);
        logic signed [S_W-1:0] v;
        logic signed [S_W-1:0] lim;
        v = e;
        if (WORK_FRAC > FRAC_BITS) begin
            v = (e + (S_W'(1) <<< (WORK_FRAC - FRAC_BITS - 1))) >>> (WORK_FRAC - FRAC_BITS);
        end
        lim = S_W'(1) <<< FRAC_BITS;
        if (v > lim) begin
            v = lim;
        end
        if (v < -lim) begin
            v = -lim;
        end
        return v[OUT_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

### hw/rtl/euler_zyx_rotation_matrix.sv
`default_nettype none
// Throughput: one angle triple per cycle while the output does not stall; set by the fully pipelined CORDIC
// lanes and the two registered multiply levels.
// A stall on the output holds the whole pipeline in place.
// Reset (synchronous, active low) clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// euler_zyx_rotation_matrix
// ZYX Euler angles to rotation matrix Rz*Ry*Rx in Q1.14, streaming.
// ----------------------------------------------------------------------------
module euler_zyx_rotation_matrix (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire logic [47:0]   i_s_tdata,   // roll_angle, pitch_angle, yaw_angle
    input  wire logic [1:0]    i_s_tuser,   // command
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [143:0]       o_m_tdata    // m00 m01 m02 m10 m11 m12 m20 m21 m22
);
    localparam int AB = eulr_pkg::ANGLE_BITS;
    localparam int LAT = eulr_pkg::LAT;
    localparam int CL = eulr_pkg::CORD_LAT;

    logic en;
    logic r_vld [LAT];
    eulr_pkg::t_cmd r_cmd [CL];

    // global advance: move when the output slot is free or being taken
    assign en         = !r_vld[LAT-1] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_vld[LAT-1];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_s_tvalid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // command delay line, aligned with the CORDIC outputs
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmd[0] <= eulr_pkg::t_cmd'(i_s_tuser);
            for (int k = 1; k < CL; k++) begin
                r_cmd[k] <= r_cmd[k-1];
            end
        end
    end

    eulr_pkg::t_q30 cx, sx, cy, sy, cz, sz;

    eulr_cordic u_cord_x (
        .i_clk(i_clk), .i_en(en), .i_angle(i_s_tdata[AB-1:0]),
        .o_cos(cx), .o_sin(sx)
    );
    eulr_cordic u_cord_y (
        .i_clk(i_clk), .i_en(en), .i_angle(i_s_tdata[16+AB-1:16]),
        .o_cos(cy), .o_sin(sy)
    );
    eulr_cordic u_cord_z (
        .i_clk(i_clk), .i_en(en), .i_angle(i_s_tdata[32+AB-1:32]),
        .o_cos(cz), .o_sin(sz)
    );

    eulr_pkg::t_elem m [9];

    eulr_matmul u_matmul (
        .i_clk(i_clk), .i_en(en), .i_cmd(r_cmd[CL-1]),
        .i_cx(cx), .i_sx(sx), .i_cy(cy), .i_sy(sy), .i_cz(cz), .i_sz(sz),
        .o_m(m)
    );

    // pack result, m00 in the lowest bits
    always_comb begin
        for (int j = 0; j < 9; j++) begin
            o_m_tdata[j*16 +: 16] = 16'(m[j]);
        end
    end

    // checks
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready == (!o_m_tvalid || i_m_tready))
        else $error("ready does not follow output slot");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("valid after reset");
    a_sat00: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[15:0]) <= 16'sd16384 &&
                        $signed(o_m_tdata[15:0]) >= -16'sd16384))
        else $error("m00 out of range");
    a_sat22: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[143:128]) <= 16'sd16384 &&
                        $signed(o_m_tdata[143:128]) >= -16'sd16384))
        else $error("m22 out of range");

endmodule
`default_nettype wire

### hw/rtl/eulr_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eulr_cordic
// Pipelined rotation-mode CORDIC lane: binary angle in, Q.30 cosine and sine
// out, one register per micro-rotation.
// ----------------------------------------------------------------------------
module eulr_cordic (
    input  wire logic                                i_clk,
    input  wire logic                                i_en,
    input  wire logic [eulr_pkg::ANGLE_BITS-1:0]     i_angle,
    output eulr_pkg::t_q30                           o_cos,
    output eulr_pkg::t_q30                           o_sin
);
    localparam int N = eulr_pkg::CORDIC_STAGES;
    localparam int XW = eulr_pkg::XY_W;
    localparam int ZW = eulr_pkg::Z_W;

    logic signed [XW-1:0] r_x [N+1];
    logic signed [XW-1:0] r_y [N+1];
    logic signed [ZW-1:0] r_z [N+1];
    logic                 r_flip [N+1];

    logic [31:0] th;
    logic [31:0] th_adj;
    logic        flip;

    // fold the angle into [-pi/2, pi/2)
    always_comb begin
        th     = 32'(i_angle) << (32 - eulr_pkg::ANGLE_BITS);
        flip   = (th[31:30] == 2'b01) || (th[31:30] == 2'b10);
        th_adj = flip ? (th + 32'h80000000) : th;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= XW'(eulr_pkg::CORD_K);
            r_y[0]    <= '0;
            r_z[0]    <= ZW'($signed(th_adj));
            r_flip[0] <= flip;
        end
    end

    // micro-rotation stages
    for (genvar i = 0; i < N; i++) begin : g_stage
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] at;
        always_comb begin
            dx = r_y[i] >>> i;
            dy = r_x[i] >>> i;
            at = ZW'(eulr_pkg::ATAN_TURN[i % 32]);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[i][ZW-1]) begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - at;
                end else begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + at;
                end
                r_flip[i+1] <= r_flip[i];
            end
        end
    end

    // undo the fold, round Q.32 to Q.30
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;
    logic signed [XW-1:0] xr;
    logic signed [XW-1:0] yr;
    always_comb begin
        xs = r_flip[N] ? -r_x[N] : r_x[N];
        ys = r_flip[N] ? -r_y[N] : r_y[N];
        xr = (xs + XW'(2)) >>> 2;
        yr = (ys + XW'(2)) >>> 2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= xr[eulr_pkg::Q_W-1:0];
            o_sin <= yr[eulr_pkg::Q_W-1:0];
        end
    end

endmodule
`default_nettype wire

### hw/rtl/eulr_matmul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eulr_matmul
// Forms the nine ZYX matrix elements from the three sine/cosine pairs:
// two registered product levels, then sums, rounding and saturation.
// ----------------------------------------------------------------------------
module eulr_matmul (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire eulr_pkg::t_cmd  i_cmd,
    input  wire eulr_pkg::t_q30  i_cx,
    input  wire eulr_pkg::t_q30  i_sx,
    input  wire eulr_pkg::t_q30  i_cy,
    input  wire eulr_pkg::t_q30  i_sy,
    input  wire eulr_pkg::t_q30  i_cz,
    input  wire eulr_pkg::t_q30  i_sz,
    output eulr_pkg::t_elem      o_m [9]
);
    localparam int SW = eulr_pkg::S_W;

    eulr_pkg::t_q30 cx, sx, cy, sy, cz, sz;

    // unused axes become identity
    always_comb begin
        cx = eulr_pkg::Q_ONE; sx = '0;
        cy = eulr_pkg::Q_ONE; sy = '0;
        cz = eulr_pkg::Q_ONE; sz = '0;
        if (i_cmd == eulr_pkg::CMD_FULL || i_cmd == eulr_pkg::CMD_ROLL) begin
            cx = i_cx; sx = i_sx;
        end
        if (i_cmd == eulr_pkg::CMD_FULL || i_cmd == eulr_pkg::CMD_PITCH) begin
            cy = i_cy; sy = i_sy;
        end
        if (i_cmd == eulr_pkg::CMD_FULL || i_cmd == eulr_pkg::CMD_YAW) begin
            cz = i_cz; sz = i_sz;
        end
    end

    // level A: two-factor products, keep sx/cx/sy for level B
    eulr_pkg::t_q30 r_czcy, r_czsy, r_szsy, r_szcy, r_szcx, r_szsx, r_czcx, r_czsx;
    eulr_pkg::t_q30 r_cysx, r_cycx, r_a_sx, r_a_cx, r_a_sy;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_czcy <= eulr_pkg::fmul(cz, cy);
            r_czsy <= eulr_pkg::fmul(cz, sy);
            r_szsy <= eulr_pkg::fmul(sz, sy);
            r_szcy <= eulr_pkg::fmul(sz, cy);
            r_szcx <= eulr_pkg::fmul(sz, cx);
            r_szsx <= eulr_pkg::fmul(sz, sx);
            r_czcx <= eulr_pkg::fmul(cz, cx);
            r_czsx <= eulr_pkg::fmul(cz, sx);
            r_cysx <= eulr_pkg::fmul(cy, sx);
            r_cycx <= eulr_pkg::fmul(cy, cx);
            r_a_sx <= sx;
            r_a_cx <= cx;
            r_a_sy <= sy;
        end
    end

    // level B: three-factor products; the other products and -sy pass through
    eulr_pkg::t_q30 r_b01, r_b02, r_b11, r_b12;
    eulr_pkg::t_q30 r_p00, r_p01, r_p02, r_p10, r_p11, r_p12, r_p20, r_p21, r_p22;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b01 <= eulr_pkg::fmul(r_czsy, r_a_sx);
            r_b02 <= eulr_pkg::fmul(r_czsy, r_a_cx);
            r_b11 <= eulr_pkg::fmul(r_szsy, r_a_sx);
            r_b12 <= eulr_pkg::fmul(r_szsy, r_a_cx);
            r_p00 <= r_czcy;
            r_p01 <= r_szcx;
            r_p02 <= r_szsx;
            r_p10 <= r_szcy;
            r_p11 <= r_czcx;
            r_p12 <= r_czsx;
            r_p20 <= -r_a_sy;
            r_p21 <= r_cysx;
            r_p22 <= r_cycx;
        end
    end

    // sums, rounding, saturation into the output register
    logic signed [SW-1:0] e [9];
    always_comb begin
        e[0] = SW'(r_p00);
        e[1] = SW'(r_b01) - SW'(r_p01);
        e[2] = SW'(r_b02) + SW'(r_p02);
        e[3] = SW'(r_p10);
        e[4] = SW'(r_b11) + SW'(r_p11);
        e[5] = SW'(r_b12) - SW'(r_p12);
        e[6] = SW'(r_p20);
        e[7] = SW'(r_p21);
        e[8] = SW'(r_p22);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 9; j++) begin
                o_m[j] <= eulr_pkg::finish(e[j]);
            end
        end
    end

endmodule
`default_nettype wire
